>>> design/msi_vector_table_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef MSI_VECTOR_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define MSI_VECTOR_TABLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSI_VTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSI_VTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/msi_vta_pkg.sv
// Types and constants of the interrupt vector table allocator.
package msi_vta_pkg;

  localparam int ACTW = 7;
  localparam int IDXW = 8;
  localparam int OWNW = 32;
  localparam int EPW  = 32;
  localparam int RIDW = 6;
  localparam logic [ACTW-1:0] ACT_RESET = 7'd64;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_REL   = 3'd3,
    CMD_DISP  = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_BAD_VEC   = 2'd2,
    STS_NOT_OWNER = 2'd3
  } status_t;

  typedef struct packed {
    status_t         status;
    logic [RIDW-1:0] result_index;
    logic [EPW-1:0]  delivered_endpoint;
    logic            flag;
  } res_t;

endpackage

>>> design/msi_vta_if.sv
// Valid/ready channel interfaces for command and result items.
interface msi_vta_in_if;
  import msi_vta_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      cmd;
  logic [IDXW-1:0] vector_index;
  logic [OWNW-1:0] owner_id;
  logic [EPW-1:0]  endpoint_value;

  modport source (output valid, cmd, vector_index, owner_id, endpoint_value, input ready);
  modport sink   (input valid, cmd, vector_index, owner_id, endpoint_value, output ready);
endinterface

interface msi_vta_out_if;
  import msi_vta_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [RIDW-1:0] result_index;
  logic [EPW-1:0]  delivered_endpoint;
  logic            flag;

  modport source (output valid, status, result_index, delivered_endpoint, flag, input ready);
  modport sink   (input valid, status, result_index, delivered_endpoint, flag, output ready);
endinterface

>>> design/msi_vector_table_allocator_unit.sv
// Interrupt vector table allocator: top level with scan sequencer and slot tables.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+----------------------------------------------
//  in_ch    | in  | valid / ready  | cmd, vector_index, owner_id, endpoint_value
//  out_ch   | out | valid / ready  | status, result_index, delivered_endpoint, flag
//  cfg      | in  | cfg_we         | cfg_wdata = active_vectors
//
// One item at a time. Clear all, query and unknown commands go from idle through the
// done state to the result register; free and dispatch first take one registered read of the slot tables.
// Allocate walks the used marks one slot a cycle until a free slot or the active count.
// Release owner reads one owner entry a cycle over the active count.
// Reset clears all used marks at once; the owner and endpoint tables need no sweep.
// A result waiting on out_ch does not block the next item; only its completion waits.
module msi_vector_table_allocator_unit #(
  parameter int VECTORS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [msi_vta_pkg::ACTW-1:0] cfg_wdata,
  msi_vta_in_if.sink                   in_ch,
  msi_vta_out_if.source                out_ch
);
  import msi_vta_pkg::*;

  localparam int IW = (VECTORS > 1) ? $clog2(VECTORS) : 1;
  localparam int CW = $clog2(VECTORS + 1);
  localparam int RW = 9;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALLOC, ST_REL, ST_FREE, ST_DISP, ST_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [ACTW-1:0] act_r, act_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            ok_r, ok_nxt;
  logic [OWNW-1:0] owner_r, owner_nxt;
  logic [EPW-1:0]  ep_r, ep_nxt;
  logic [VECTORS-1:0] use_r, use_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  res_t            pend_r, pend_nxt;
  res_t            out_r, out_nxt;
  logic            out_vld_r, out_vld_nxt;

  logic [OWNW-1:0] own_mem [VECTORS];
  logic [EPW-1:0]  ep_mem  [VECTORS];
  logic [OWNW-1:0] own_q;
  logic [EPW-1:0]  ep_q;
  logic            mem_we;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   in_idx;

  logic            acc;
  logic            idx_in_ok;
  logic [CW-1:0]   cnt_in;

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_idx      = in_ch.vector_index[IW-1:0];

  assign idx_in_ok = ({1'b0, in_ch.vector_index} < {2'b00, act_r}) &&
                     ({1'b0, in_ch.vector_index} < RW'(VECTORS));
  assign cnt_in    = (RW'(act_r) < RW'(VECTORS)) ? CW'(act_r) : CW'(VECTORS);

  // Address the slot of the new item while idle, else the scan pointer.
  assign rd_addr = (state_r == ST_IDLE) ? in_idx : ptr_r[IW-1:0];

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    idx_nxt     = idx_r;
    ok_nxt      = ok_r;
    owner_nxt   = owner_r;
    ep_nxt      = ep_r;
    use_nxt     = use_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    pend_nxt    = pend_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    mem_we      = 1'b0;

    if (cfg_we) begin
      act_nxt = cfg_wdata;
    end
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          idx_nxt     = in_idx;
          ok_nxt      = idx_in_ok;
          owner_nxt   = in_ch.owner_id;
          ep_nxt      = in_ch.endpoint_value;
          cnt_nxt     = cnt_in;
          ptr_nxt     = '0;
          chk_vld_nxt = 1'b0;
          pend_nxt    = '0;
          case (in_ch.cmd)
            CMD_CLEAR: begin
              use_nxt   = '0;
              state_nxt = ST_DONE;
            end
            CMD_ALLOC: state_nxt = ST_ALLOC;
            CMD_FREE:  state_nxt = ST_FREE;
            CMD_REL:   state_nxt = ST_REL;
            CMD_DISP:  state_nxt = ST_DISP;
            CMD_QUERY: begin
              pend_nxt.flag = idx_in_ok && use_r[in_idx];
              state_nxt     = ST_DONE;
            end
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (ptr_r == cnt_r) begin
          pend_nxt.status = STS_NO_FREE;
          state_nxt       = ST_DONE;
        end else if (!use_r[ptr_r[IW-1:0]]) begin
          use_nxt[ptr_r[IW-1:0]] = 1'b1;
          mem_we                 = 1'b1;
          pend_nxt.result_index  = RIDW'(ptr_r);
          state_nxt              = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_REL: begin
        // Compare stage works on the registered read of the previous pointer value.
        if (chk_vld_r && use_r[chk_idx_r] && (own_q == owner_r)) begin
          use_nxt[chk_idx_r] = 1'b0;
        end
        if (ptr_r != cnt_r) begin
          ptr_nxt     = ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = ptr_r[IW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FREE: begin
        if (!ok_r || !use_r[idx_r]) begin
          pend_nxt.status = STS_BAD_VEC;
        end else if (own_q != owner_r) begin
          pend_nxt.status = STS_NOT_OWNER;
        end else begin
          use_nxt[idx_r] = 1'b0;
        end
        state_nxt = ST_DONE;
      end
      ST_DISP: begin
        if (ok_r && use_r[idx_r]) begin
          pend_nxt.flag               = 1'b1;
          pend_nxt.result_index       = RIDW'(idx_r);
          pend_nxt.delivered_endpoint = ep_q;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_vld_r || out_ch.ready) begin
          out_nxt     = pend_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      act_r     <= ACT_RESET;
      use_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      act_r     <= act_nxt;
      use_r     <= use_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cnt_r     <= cnt_nxt;
    ptr_r     <= ptr_nxt;
    idx_r     <= idx_nxt;
    ok_r      <= ok_nxt;
    owner_r   <= owner_nxt;
    ep_r      <= ep_nxt;
    chk_idx_r <= chk_idx_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  // Owner and endpoint tables: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      own_mem[ptr_r[IW-1:0]] <= owner_r;
      ep_mem[ptr_r[IW-1:0]]  <= ep_r;
    end
    own_q <= own_mem[rd_addr];
    ep_q  <= ep_mem[rd_addr];
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.status             = out_r.status;
  assign out_ch.result_index       = out_r.result_index;
  assign out_ch.delivered_endpoint = out_r.delivered_endpoint;
  assign out_ch.flag               = out_r.flag;

`include "msi_vector_table_allocator_unit_macros.svh"

  `MSI_VTA_ASSERT_NXT(a_clear_all, acc && (in_ch.cmd == CMD_CLEAR), use_r == '0, "clear all left a slot in use")
  `MSI_VTA_ASSERT_NOW(a_ptr_range, (state_r == ST_ALLOC) || (state_r == ST_REL), ptr_r <= cnt_r, "scan pointer beyond active count")
  `MSI_VTA_ASSERT_NXT(a_alloc_grows, state_r == ST_ALLOC, $countones(use_r) >= $past($countones(use_r)), "allocate dropped a used slot")
  `MSI_VTA_ASSERT_NXT(a_done_hold, (state_r == ST_DONE) && out_vld_r && !out_ch.ready, state_r == ST_DONE, "result overwrote a pending item")
  `MSI_VTA_ASSERT_NOW(a_cnt_cap, state_r != ST_IDLE, cnt_r <= CW'(VECTORS), "active count exceeds table size")

endmodule
